// ===== design/psp_pkg.sv =====
// Shared types, constants and tables of the sample playback voice block.
package psp_pkg;

    // Item kinds carried on s_tuser.
    localparam logic [1:0] FUNC_LOAD     = 2'd0;
    localparam logic [1:0] FUNC_MIDI     = 2'd1;
    localparam logic [1:0] FUNC_RENDER   = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    // MIDI status decoding.
    localparam logic [7:0] MIDI_TYPE_MASK = 8'hF0;
    localparam logic [7:0] MIDI_NOTE_ON   = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF  = 8'h80;

    // Configuration register indexes.
    localparam logic [2:0] REG_BASE_STEP      = 3'd0;
    localparam logic [2:0] REG_ROOT_NOTE      = 3'd1;
    localparam logic [2:0] REG_STEREO         = 3'd2;
    localparam logic [2:0] REG_FRAME_COUNT    = 3'd3;
    localparam logic [2:0] REG_RELEASE_STEP   = 3'd4;
    localparam logic [2:0] REG_FIXED_VELOCITY = 3'd5;

    // Sample memory geometry and position format.
    localparam int SAMPLE_WORDS = 65536;
    localparam int ADDR_W       = 16;
    localparam int FRAC_BITS    = 16;
    localparam int POS_W        = 34;
    localparam int MIX_W        = 58;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

    // Operand pair handed to the shared multiplier.
    typedef struct packed {
        mul_a_t a;
        mul_b_t b;
    } mul_req_t;

    // Semitone ratios 2^(k/12) in Q16, rounded.
    function automatic logic [16:0] semi_ratio(input logic [3:0] k);
        logic [16:0] r;
        begin
            case (k)
                4'd0:    r = 17'd65536;
                4'd1:    r = 17'd69433;
                4'd2:    r = 17'd73562;
                4'd3:    r = 17'd77936;
                4'd4:    r = 17'd82570;
                4'd5:    r = 17'd87480;
                4'd6:    r = 17'd92682;
                4'd7:    r = 17'd98193;
                4'd8:    r = 17'd104032;
                4'd9:    r = 17'd110218;
                4'd10:   r = 17'd116772;
                4'd11:   r = 17'd123715;
                default: r = 17'd65536;
            endcase
            return r;
        end
    endfunction

    // Builds the velocity to Q1.15 volume table at elaboration.
    function automatic logic [127:0][15:0] vol_table();
        logic [127:0][15:0] t;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bitv;
        begin
            for (int v = 0; v < 128; v++) begin
                x = (64'(v) << 30) / 64'd127;
                r = 64'd0;
                bitv = 64'd1 << 62;
                while (bitv > x) bitv = bitv >> 2;
                while (bitv != 64'd0) begin
                    if (x >= r + bitv) begin
                        x = x - (r + bitv);
                        r = (r >> 1) + bitv;
                    end else begin
                        r = r >> 1;
                    end
                    bitv = bitv >> 2;
                end
                t[v] = r[15:0];
            end
            return t;
        end
    endfunction

    localparam logic [127:0][15:0] VOL_ROM = vol_table();

endpackage

// ===== design/psp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/psp_mul.sv =====
// Shared signed multiplier with a registered product.
module psp_mul
    import psp_pkg::*;
(
    input  logic     aclk,
    input  mul_req_t req,
    output mul_p_t   prod
);

    always_ff @(posedge aclk) begin
        prod <= req.a * req.b;
    end

endmodule

// ===== design/polyphonic_sample_playback_voices.sv =====
// Sample playback voices. Load words go straight into the sample RAM and
// note-offs take effect as they are accepted; note-on scans the voices (one per
// cycle), then splits the key distance into octaves and semitones and forms
// the step. A render walks the voices one by one through a single multiplier
// and the single read port of the sample RAM: an idle voice is skipped, an
// active one is read, interpolated and accumulated per channel and then
// advanced, and a final state forms the output word. The input is not ready
// while an item is being worked on; a finished output word waits in its own
// register.
module polyphonic_sample_playback_voices
    import psp_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[15:0], sample_value[31:16], status_byte[39:32],
    // key_number[46:40], key_velocity[53:47], zero fill above
    input  logic [55:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // left_out[15:0], right_out[31:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_OCT    = 4'd2;
    localparam logic [3:0] ST_SMUL   = 4'd3;
    localparam logic [3:0] ST_NWR    = 4'd4;
    localparam logic [3:0] ST_VSTART = 4'd5;
    localparam logic [3:0] ST_RDA    = 4'd6;
    localparam logic [3:0] ST_RDB    = 4'd7;
    localparam logic [3:0] ST_DIFF   = 4'd8;
    localparam logic [3:0] ST_INTERP = 4'd9;
    localparam logic [3:0] ST_ACC    = 4'd10;
    localparam logic [3:0] ST_ADV    = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    // Configuration registers.
    logic [23:0] base_step_reg;
    logic [6:0]  root_note_reg;
    logic        stereo_reg;
    logic [16:0] frame_count_reg;
    logic [16:0] release_step_reg;
    logic [6:0]  fixed_velocity_reg;

    // Voice state.
    logic             active_reg    [VOICES];
    logic [6:0]       key_reg       [VOICES];
    logic [POS_W-1:0] pos_reg       [VOICES];
    logic [23:0]      step_reg      [VOICES];
    logic [15:0]      vol_reg       [VOICES];
    logic [16:0]      gain_reg      [VOICES];
    logic             releasing_reg [VOICES];

    // Sequencer state.
    logic [3:0]              state_reg;
    logic [VW-1:0]           vi_reg;
    logic [VW-1:0]           pick_reg;
    logic [POS_W-1:0]        best_pos_reg;
    logic [6:0]              nkey_reg;
    logic [6:0]              nvel_reg;
    logic signed [8:0]       semi_reg;
    logic signed [4:0]       oct_reg;
    logic                    chan_reg;
    logic [16:0]             amp_reg;
    logic signed [15:0]      a_word_reg;
    logic signed [MIX_W-1:0] mix0_reg;
    logic signed [MIX_W-1:0] mix1_reg;
    logic                    m_tvalid_reg;
    logic [31:0]             m_tdata_reg;

    // Input field views.
    logic [15:0] in_address;
    logic [15:0] in_sample;
    logic [7:0]  in_status;
    logic [6:0]  in_key;
    logic [6:0]  in_vel;
    logic        s_acc;
    logic        note_on_go;
    logic        note_off_go;

    assign in_address = s_tdata[15:0];
    assign in_sample  = s_tdata[31:16];
    assign in_status  = s_tdata[39:32];
    assign in_key     = s_tdata[46:40];
    assign in_vel     = s_tdata[53:47];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign note_on_go = s_acc && (s_tuser == FUNC_MIDI)
        && ((in_status & MIDI_TYPE_MASK) == MIDI_NOTE_ON) && (in_vel != 7'd0);
    assign note_off_go = s_acc && (s_tuser == FUNC_MIDI) && !note_on_go
        && (((in_status & MIDI_TYPE_MASK) == MIDI_NOTE_ON)
            || ((in_status & MIDI_TYPE_MASK) == MIDI_NOTE_OFF));

    // Current voice views.
    logic             cur_active;
    logic [POS_W-1:0] cur_pos;
    logic [17:0]      cur_idx;
    logic [15:0]      cur_frac;
    logic             last_voice;

    assign cur_active = active_reg[vi_reg];
    assign cur_pos    = pos_reg[vi_reg];
    assign cur_idx    = cur_pos[POS_W-1:FRAC_BITS];
    assign cur_frac   = cur_pos[FRAC_BITS-1:0];
    assign last_voice = (vi_reg == VW'(VOICES - 1));

    // Sample RAM addressing: interleaved pairs put the channel in the low bit.
    logic [17:0]       idx_next;
    logic [ADDR_W-1:0] word_a;
    logic [ADDR_W-1:0] word_b;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    assign idx_next = cur_idx + 18'd1;
    assign word_a = stereo_reg ? {cur_idx[ADDR_W-2:0], chan_reg} : cur_idx[ADDR_W-1:0];
    assign word_b = stereo_reg ? {idx_next[ADDR_W-2:0], chan_reg} : idx_next[ADDR_W-1:0];
    assign ram_raddr = (state_reg == ST_RDB) ? word_b : word_a;

    psp_ram #(
        .WIDTH(16),
        .DEPTH(SAMPLE_WORDS)
    ) u_sample_ram (
        .aclk (aclk),
        .we   (s_acc && (s_tuser == FUNC_LOAD)),
        .waddr(in_address),
        .wdata(in_sample),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Operand selection for the shared multiplier.
    mul_req_t          mreq;
    mul_p_t            prod;
    logic signed [16:0] diff;
    logic signed [32:0] interp_val;

    assign diff = {ram_rdata[15], ram_rdata} - {a_word_reg[15], a_word_reg};
    assign interp_val = {a_word_reg[15], a_word_reg, 16'd0} + prod[32:0];

    always_comb begin
        mreq.a = '0;
        mreq.b = '0;
        case (state_reg)
            ST_SMUL: begin
                mreq.a = {9'd0, base_step_reg};
                mreq.b = {1'b0, semi_ratio(semi_reg[3:0])};
            end
            ST_VSTART: begin
                mreq.a = {16'd0, gain_reg[vi_reg]};
                mreq.b = {2'd0, vol_reg[vi_reg]};
            end
            ST_DIFF: begin
                mreq.a = {{16{diff[16]}}, diff};
                mreq.b = {2'd0, cur_frac};
            end
            ST_INTERP: begin
                mreq.a = interp_val;
                mreq.b = {1'b0, amp_reg};
            end
            default: begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    psp_mul u_mul (
        .aclk(aclk),
        .req (mreq),
        .prod(prod)
    );

    // Pitch step from the ratio product, shifted by octaves and saturated.
    logic [4:0]  step_shift;
    logic [40:0] step_wide;
    logic [23:0] new_step;

    assign step_shift = 5'(6'sd16 - {oct_reg[4], oct_reg});
    assign step_wide  = prod[40:0] >> step_shift;
    assign new_step   = (step_wide > 41'hFFFFFF) ? 24'hFFFFFF : step_wide[23:0];

    // Advance, fade and end test of the current voice.
    logic [16:0]      fc_m1;
    logic [POS_W-1:0] limit;
    logic [POS_W-1:0] adv_pos;
    logic [16:0]      adv_gain;
    logic             retire;

    assign fc_m1   = (frame_count_reg >= 17'd1) ? frame_count_reg - 17'd1 : 17'd0;
    assign limit   = {1'b0, fc_m1, 16'd0};
    assign adv_pos = cur_pos + {10'd0, step_reg[vi_reg]};
    always_comb begin
        adv_gain = gain_reg[vi_reg];
        if (releasing_reg[vi_reg]) begin
            adv_gain = (gain_reg[vi_reg] > release_step_reg)
                ? gain_reg[vi_reg] - release_step_reg : 17'd0;
        end
    end
    assign retire = (adv_gain == 17'd0) || (adv_pos >= limit);

    // Final scaling: divide by 2^32 toward zero, then clamp to 16 bits.
    logic signed [MIX_W-1:0] bias0;
    logic signed [MIX_W-1:0] bias1;
    logic signed [25:0]      q0;
    logic signed [25:0]      q1;
    logic [15:0]             out0;
    logic [15:0]             out1;

    assign bias0 = mix0_reg + (mix0_reg[MIX_W-1] ? MIX_W'(33'hFFFFFFFF) : '0);
    assign bias1 = mix1_reg + (mix1_reg[MIX_W-1] ? MIX_W'(33'hFFFFFFFF) : '0);
    assign q0 = bias0[MIX_W-1:32];
    assign q1 = bias1[MIX_W-1:32];
    assign out0 = (q0 > 26'sd32767) ? 16'h7FFF : (q0 < -26'sd32768) ? 16'h8000 : q0[15:0];
    assign out1 = (q1 > 26'sd32767) ? 16'h7FFF : (q1 < -26'sd32768) ? 16'h8000 : q1[15:0];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_step_reg      <= 24'd65536;
            root_note_reg      <= 7'd60;
            stereo_reg         <= 1'b0;
            frame_count_reg    <= 17'd2;
            release_step_reg   <= 17'd46;
            fixed_velocity_reg <= 7'd100;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_STEP:      base_step_reg      <= cfg_wr_data;
                REG_ROOT_NOTE:      root_note_reg      <= cfg_wr_data[6:0];
                REG_STEREO:         stereo_reg         <= cfg_wr_data[0];
                REG_FRAME_COUNT:    frame_count_reg    <= cfg_wr_data[16:0];
                REG_RELEASE_STEP:   release_step_reg   <= cfg_wr_data[16:0];
                REG_FIXED_VELOCITY: fixed_velocity_reg <= cfg_wr_data[6:0];
                default: ;
            endcase
        end
    end

    // Voice state updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                active_reg[i]    <= 1'b0;
                key_reg[i]       <= 7'd0;
                pos_reg[i]       <= '0;
                step_reg[i]      <= 24'd65536;
                vol_reg[i]       <= 16'd32768;
                gain_reg[i]      <= 17'd65536;
                releasing_reg[i] <= 1'b0;
            end
        end else begin
            // Note-off marks every matching held voice at once.
            if (note_off_go) begin
                for (int i = 0; i < VOICES; i++) begin
                    if (active_reg[i] && (key_reg[i] == in_key) && !releasing_reg[i]) begin
                        releasing_reg[i] <= 1'b1;
                    end
                end
            end
            if (state_reg == ST_NWR) begin
                active_reg[pick_reg]    <= 1'b1;
                key_reg[pick_reg]       <= nkey_reg;
                pos_reg[pick_reg]       <= '0;
                step_reg[pick_reg]      <= new_step;
                vol_reg[pick_reg]       <= VOL_ROM[nvel_reg];
                gain_reg[pick_reg]      <= 17'd65536;
                releasing_reg[pick_reg] <= 1'b0;
            end
            if (state_reg == ST_ADV) begin
                pos_reg[vi_reg]  <= adv_pos;
                gain_reg[vi_reg] <= adv_gain;
                if (retire) begin
                    active_reg[vi_reg] <= 1'b0;
                end
            end
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            vi_reg       <= '0;
            chan_reg     <= 1'b0;
        end else begin
            // The final state refills the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (note_on_go) begin
                        nkey_reg  <= in_key;
                        nvel_reg  <= (fixed_velocity_reg != 7'd0) ? fixed_velocity_reg : in_vel;
                        semi_reg  <= 9'(signed'({2'b0, in_key}) - signed'({2'b0, root_note_reg}));
                        oct_reg   <= 5'sd0;
                        vi_reg    <= '0;
                        state_reg <= ST_SCAN;
                    end else if (s_acc && (s_tuser == FUNC_RENDER)) begin
                        mix0_reg  <= '0;
                        mix1_reg  <= '0;
                        vi_reg    <= '0;
                        state_reg <= ST_VSTART;
                    end
                end
                ST_SCAN: begin
                    // First free voice wins; otherwise the one furthest along.
                    if (!cur_active) begin
                        pick_reg  <= vi_reg;
                        state_reg <= ST_OCT;
                    end else begin
                        if ((vi_reg == '0) || (cur_pos > best_pos_reg)) begin
                            pick_reg     <= vi_reg;
                            best_pos_reg <= cur_pos;
                        end
                        if (last_voice) begin
                            state_reg <= ST_OCT;
                        end else begin
                            vi_reg <= vi_reg + VW'(1);
                        end
                    end
                end
                ST_OCT: begin
                    // Floor split of the key distance into octaves and semitones.
                    if (semi_reg < 9'sd0) begin
                        semi_reg <= semi_reg + 9'sd12;
                        oct_reg  <= oct_reg - 5'sd1;
                    end else if (semi_reg >= 9'sd12) begin
                        semi_reg <= semi_reg - 9'sd12;
                        oct_reg  <= oct_reg + 5'sd1;
                    end else begin
                        state_reg <= ST_SMUL;
                    end
                end
                ST_SMUL: begin
                    state_reg <= ST_NWR;
                end
                ST_NWR: begin
                    state_reg <= ST_IDLE;
                end
                ST_VSTART: begin
                    chan_reg <= 1'b0;
                    if (cur_active) begin
                        state_reg <= ST_RDA;
                    end else if (last_voice) begin
                        state_reg <= ST_FIN;
                    end else begin
                        vi_reg <= vi_reg + VW'(1);
                    end
                end
                ST_RDA: begin
                    if (!chan_reg) begin
                        amp_reg <= prod[31:15];
                    end
                    state_reg <= ST_RDB;
                end
                ST_RDB: begin
                    a_word_reg <= ram_rdata;
                    state_reg  <= ST_DIFF;
                end
                ST_DIFF: begin
                    state_reg <= ST_INTERP;
                end
                ST_INTERP: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (chan_reg) begin
                        mix1_reg <= mix1_reg + MIX_W'(prod);
                    end else begin
                        mix0_reg <= mix0_reg + MIX_W'(prod);
                    end
                    if (stereo_reg && !chan_reg) begin
                        chan_reg  <= 1'b1;
                        state_reg <= ST_RDA;
                    end else begin
                        state_reg <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    if (last_voice) begin
                        state_reg <= ST_FIN;
                    end else begin
                        vi_reg    <= vi_reg + VW'(1);
                        state_reg <= ST_VSTART;
                    end
                end
                ST_FIN: begin
                    // Hold the word until the output register is free.
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {stereo_reg ? out1 : 16'd0, out0};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/psp_checker.sv =====
// Port-level checks of the sample playback voice block and their binding.
module psp_checker
    import psp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed");

    // No word appears in the cycle right after an accepted input word while the output was empty.
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
        else $error("output word appeared too early");

    // An accepted render closes the input.
    a_render_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_RENDER)) |=> !s_tready)
        else $error("input open during render");

endmodule

bind polyphonic_sample_playback_voices psp_checker u_psp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

// ===== test/psp_checker.sv =====
// Checker for the sample playback voices: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module psp_scoreboard
    import psp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data,
    output int          errors,
    output int          pending,
    output int          frames_checked
);

    localparam int NV = 16;

    // Semitone ratios 2^(k/12) in Q16.
    localparam logic [16:0] SEMITONE [0:11] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } frame_t;

    frame_t frame_q[$];

    // Shadow copy of the registers.
    logic [23:0] base_step;
    logic [6:0]  root_note;
    logic        stereo;
    logic [16:0] frame_count;
    logic [16:0] release_step;
    logic [6:0]  fixed_velocity;

    // Shadow copy of the sample RAM and voice bank.
    logic [15:0]       samples [0:SAMPLE_WORDS-1];
    bit                v_on   [NV];
    logic [6:0]        v_key  [NV];
    longint unsigned   v_pos  [NV];
    logic [23:0]       v_step [NV];
    logic [15:0]       v_vol  [NV];
    logic [16:0]       v_gain [NV];
    bit                v_rel  [NV];

    // Integer square root by bit-by-bit search from the top.
    function automatic logic [15:0] vel_volume(input logic [6:0] vel);
        longint unsigned x;
        longint unsigned r;
        longint unsigned t;
        x = (longint'(vel) << 30) / 127;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r[15:0];
    endfunction

    // Pitch step of a key relative to the root, saturated to 24 bits.
    function automatic logic [23:0] key_step(input logic [6:0] key);
        int d;
        int oct;
        int semi;
        longint unsigned prod;
        longint unsigned s;
        d = int'(key) - int'(root_note);
        oct = (d >= 0) ? d / 12 : -((-d + 11) / 12);
        semi = d - 12 * oct;
        prod = longint'(base_step) * longint'(SEMITONE[semi]);
        s = prod >> (16 - oct);
        return (s > 64'hFF_FFFF) ? 24'hFF_FFFF : s[23:0];
    endfunction

    function automatic longint word_at(input longint unsigned frame, input int ch, input int c);
        longint unsigned w;
        logic [15:0] idx;
        w = frame * ch + c;
        idx = w[15:0];
        return longint'($signed(samples[idx]));
    endfunction

    task automatic note_on(input logic [6:0] key, input logic [6:0] vel);
        int pick;
        logic [6:0] v;
        pick = -1;
        for (int i = 0; i < NV; i++) begin
            if (!v_on[i]) begin
                pick = i;
                break;
            end
            if (pick < 0 || v_pos[i] > v_pos[pick]) pick = i;
        end
        v = (fixed_velocity != 0) ? fixed_velocity : vel;
        v_on[pick]   = 1'b1;
        v_key[pick]  = key;
        v_pos[pick]  = 0;
        v_step[pick] = key_step(key);
        v_vol[pick]  = vel_volume(v);
        v_gain[pick] = 17'd65536;
        v_rel[pick]  = 1'b0;
    endtask

    task automatic key_release(input logic [6:0] key);
        for (int i = 0; i < NV; i++)
            if (v_on[i] && v_key[i] == key && !v_rel[i]) v_rel[i] = 1'b1;
    endtask

    // One output frame: mix, then advance, fade and retire each voice.
    task automatic mix_frame(output frame_t f);
        longint mix [2];
        longint a;
        longint b;
        longint frac;
        longint amp;
        longint q;
        longint unsigned idx;
        longint unsigned limit;
        int ch;
        logic signed [15:0] outs [2];
        mix[0] = 0;
        mix[1] = 0;
        ch = stereo ? 2 : 1;
        limit = longint'((frame_count >= 1) ? frame_count - 1 : 0) << 16;
        for (int i = 0; i < NV; i++) begin
            if (!v_on[i]) continue;
            idx  = v_pos[i] >> 16;
            frac = longint'(v_pos[i] & 64'hFFFF);
            amp  = (longint'(v_vol[i]) * longint'(v_gain[i])) >>> 15;
            for (int c = 0; c < ch; c++) begin
                a = word_at(idx, ch, c);
                b = word_at(idx + 1, ch, c);
                mix[c] += (a * 65536 + (b - a) * frac) * amp;
            end
            v_pos[i] += longint'(v_step[i]);
            if (v_rel[i])
                v_gain[i] = (v_gain[i] > release_step) ? v_gain[i] - release_step : 17'd0;
            if (v_gain[i] == 0 || v_pos[i] >= limit) v_on[i] = 1'b0;
        end
        for (int c = 0; c < 2; c++) begin
            q = mix[c] / 64'sh1_0000_0000;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            outs[c] = q[15:0];
        end
        f.left  = outs[0];
        f.right = stereo ? outs[1] : 16'sd0;
    endtask

    always @(posedge aclk) begin
        frame_t f;
        logic [7:0] kind;
        if (!aresetn) begin
            frame_q.delete();
            errors = 0;
            frames_checked = 0;
            base_step = 24'd65536;
            root_note = 7'd60;
            stereo = 1'b0;
            frame_count = 17'd2;
            release_step = 17'd46;
            fixed_velocity = 7'd100;
            for (int i = 0; i < NV; i++) begin
                v_on[i] = 1'b0;
                v_key[i] = '0;
                v_pos[i] = 0;
                v_step[i] = 24'd65536;
                v_vol[i] = 16'd32768;
                v_gain[i] = 17'd65536;
                v_rel[i] = 1'b0;
            end
        end else begin
            // Result side: compare against the oldest predicted frame.
            if (m_tvalid && m_tready) begin
                frames_checked++;
                if (frame_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: output word %h with no frame pending", $time, m_tdata);
                end else begin
                    f = frame_q.pop_front();
                    if (m_tdata[15:0] !== f.left || m_tdata[31:16] !== f.right) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: frame mismatch left exp %0d got %0d, right exp %0d got %0d",
                                     $time, f.left, $signed(m_tdata[15:0]),
                                     f.right, $signed(m_tdata[31:16]));
                    end
                end
            end

            // Register writes.
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_BASE_STEP:      base_step = cfg_wr_data;
                    REG_ROOT_NOTE:      root_note = cfg_wr_data[6:0];
                    REG_STEREO:         stereo = cfg_wr_data[0];
                    REG_FRAME_COUNT:    frame_count = cfg_wr_data[16:0];
                    REG_RELEASE_STEP:   release_step = cfg_wr_data[16:0];
                    REG_FIXED_VELOCITY: fixed_velocity = cfg_wr_data[6:0];
                    default: ;
                endcase
            end

            // Input side: update the model for each accepted word.
            if (s_tvalid && s_tready) begin
                kind = s_tdata[39:32] & MIDI_TYPE_MASK;
                case (s_tuser)
                    FUNC_LOAD: samples[s_tdata[15:0]] = s_tdata[31:16];
                    FUNC_MIDI: begin
                        if (kind == MIDI_NOTE_ON && s_tdata[53:47] != 0)
                            note_on(s_tdata[46:40], s_tdata[53:47]);
                        else if (kind == MIDI_NOTE_ON || kind == MIDI_NOTE_OFF)
                            key_release(s_tdata[46:40]);
                    end
                    FUNC_RENDER: begin
                        mix_frame(f);
                        frame_q.push_back(f);
                    end
                    default: ;
                endcase
            end
        end
        pending = frame_q.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench
    import psp_pkg::*;
();

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // address[15:0], sample_value[31:16], status_byte[39:32],
    // key_number[46:40], key_velocity[53:47], zero fill above
    logic [55:0] s_tdata;
    // func[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // left_out[15:0], right_out[31:16]
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [23:0] cfg_wr_data;

    int errors;
    int pending;
    int frames_checked;

    bit calm;
    bit hold_req;
    bit [127:0] started;
    int n_words;
    int n_notes;
    int n_phases;
    int stall_cycles;

    // Current phase settings mirrored for stimulus choices.
    int cur_root;
    int cur_ch;
    int cur_fc;
    int span_words;
    bit cur_big;

    polyphonic_sample_playback_voices dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    psp_scoreboard chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .errors(errors), .pending(pending), .frames_checked(frames_checked)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: too long without any accepted word ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            stall_cycles = 0;
        else if (++stall_cycles >= 20000) begin
            $display("watchdog: no traffic for %0d cycles", stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, with one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (3000) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready = calm || ($urandom_range(0, 99) >= 20);
            end
        end
    end

    function automatic logic [55:0] pack(input logic [15:0] addr, input logic [15:0] val,
                                         input logic [7:0] status, input logic [6:0] key,
                                         input logic [6:0] vel);
        return {2'b00, vel, key, status, val, addr};
    endfunction

    task automatic push_word(input logic [1:0] fn, input logic [55:0] data);
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = fn;
        do @(posedge aclk); while (!s_tready);
        n_words++;
    endtask

    task automatic load_word(input int addr, input logic [15:0] val);
        push_word(FUNC_LOAD, pack(addr[15:0], val, 8'($urandom), 7'($urandom), 7'($urandom)));
    endtask

    task automatic midi(input logic [7:0] status, input int key, input int vel);
        if ((status & MIDI_TYPE_MASK) == MIDI_NOTE_ON && vel != 0) begin
            started[key] = 1'b1;
            n_notes++;
        end
        push_word(FUNC_MIDI, pack(16'($urandom), 16'($urandom), status, key[6:0], vel[6:0]));
    endtask

    task automatic render();
        push_word(FUNC_RENDER, pack(16'($urandom), 16'($urandom), 8'($urandom),
                                    7'($urandom), 7'($urandom)));
    endtask

    // Wait until every frame is out and the block has had time to settle.
    task automatic quiesce();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (300) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = idx;
        cfg_wr_data = val[23:0];
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    // Fade out every voice at once so the next phase starts from silence.
    task automatic silence();
        quiesce();
        write_reg(REG_RELEASE_STEP, 65536);
        write_reg(REG_FRAME_COUNT, 2);
        for (int k = 0; k < 128; k++)
            if (started[k]) midi(MIDI_NOTE_OFF | 8'($urandom_range(0, 15)), k, 0);
        render();
        quiesce();
        started = '0;
    endtask

    // New settings, then fresh sample content over the span voices can reach.
    task automatic set_phase(input int base, input int root, input int st, input int fc,
                             input int rs, input int fv);
        silence();
        write_reg(REG_BASE_STEP, base);
        write_reg(REG_ROOT_NOTE, root);
        write_reg(REG_STEREO, st);
        write_reg(REG_FRAME_COUNT, fc);
        write_reg(REG_RELEASE_STEP, rs);
        write_reg(REG_FIXED_VELOCITY, fv);
        cur_root = root;
        cur_ch = st ? 2 : 1;
        cur_fc = fc;
        cur_big = fc > 64;
        span_words = (cur_big ? 44 : fc) * cur_ch;
        if (span_words > 65536) span_words = 65536;
        for (int w = 0; w < span_words; w++) load_word(w, 16'($urandom));
        n_phases++;
    endtask

    // Random traffic for one phase; long-sample phases keep keys at or below
    // the root and cap the renders so voices stay inside the loaded span.
    task automatic random_phase(input int items);
        int r;
        int key;
        int frames;
        int recent [8];
        frames = 0;
        for (int i = 0; i < 8; i++) recent[i] = cur_root;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35 && !(cur_big && frames >= 40)) begin
                render();
                frames++;
            end else if (r < 65) begin
                if (cur_big)
                    key = cur_root - $urandom_range(0, cur_root);
                else if ($urandom_range(0, 1))
                    key = $urandom_range(0, 127);
                else begin
                    key = cur_root + $urandom_range(0, 48) - 24;
                    if (key < 0) key = 0;
                    if (key > 127) key = 127;
                end
                recent[$urandom_range(0, 7)] = key;
                midi(MIDI_NOTE_ON | 8'($urandom_range(0, 15)), key, $urandom_range(1, 127));
            end else if (r < 88) begin
                key = recent[$urandom_range(0, 7)];
                if ($urandom_range(0, 1))
                    midi(MIDI_NOTE_OFF | 8'($urandom_range(0, 15)), key, $urandom_range(0, 127));
                else
                    midi(MIDI_NOTE_ON | 8'($urandom_range(0, 15)), key, 0);
            end else if (r < 94) begin
                load_word($urandom_range(0, span_words - 1), 16'($urandom));
            end else if ($urandom_range(0, 1)) begin
                push_word(FUNC_RESERVED, pack(16'($urandom), 16'($urandom), 8'($urandom),
                                              7'($urandom), 7'($urandom)));
            end else begin
                // Status bytes other than note-on and note-off.
                do r = $urandom_range(0, 255);
                while ((r[7:0] & MIDI_TYPE_MASK) == MIDI_NOTE_OFF
                       || (r[7:0] & MIDI_TYPE_MASK) == MIDI_NOTE_ON);
                midi(r[7:0], $urandom_range(0, 127), $urandom_range(0, 127));
            end
        end
    endtask

    initial begin
        int base;
        int fc;
        int rs;
        int fv;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_BASE_STEP;
        cfg_wr_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        started = '0;
        n_words = 0;
        n_notes = 0;
        n_phases = 0;
        stall_cycles = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed part under reset settings: extreme words, every item kind,
        // ignored messages, velocity-zero note-on, double note-off, stealing.
        load_word(0, 16'h8000);
        load_word(1, 16'h7FFF);
        load_word(65535, 16'h5A5A);
        midi(MIDI_NOTE_ON, 60, 127);
        render();
        midi(8'hA3, 60, 100);
        midi(MIDI_NOTE_ON | 8'h0F, 0, 1);
        midi(MIDI_NOTE_ON, 127, 64);
        render();
        midi(MIDI_NOTE_ON, 0, 0);
        midi(MIDI_NOTE_OFF, 0, 127);
        push_word(FUNC_RESERVED, pack(16'hFFFF, 16'hFFFF, 8'hFF, 7'h7F, 7'h7F));
        for (int k = 0; k < 17; k++) midi(MIDI_NOTE_ON, k * 7, 100);
        render();
        render();
        cur_root = 60;

        // Phases with extreme settings among random ones.
        for (int p = 0; p < 10; p++) begin
            calm = (p == 3);
            case (p)
                0: set_phase(24'hFF_FFFF, 0, 0, 16, 65536, 127);
                1: set_phase(0, 127, 1, 8, 0, 0);
                2: set_phase(65536, 60, 1, 65536, 46, 100);
                4: set_phase(65536, 127, 0, 65536, 0, 0);
                default: begin
                    base = $urandom_range(0, 1) ? $urandom_range(16384, 200000)
                                                : $urandom_range(0, 24'hFF_FFFF);
                    fc = $urandom_range(2, 32);
                    case ($urandom_range(0, 2))
                        0: rs = 0;
                        1: rs = $urandom_range(1, 4000);
                        default: rs = 65536;
                    endcase
                    fv = $urandom_range(0, 1) ? 0 : $urandom_range(1, 127);
                    set_phase(base, $urandom_range(0, 127), $urandom_range(0, 1), fc, rs, fv);
                end
            endcase
            if (p == 5) hold_req = 1'b1;
            random_phase(110);
        end
        calm = 1'b0;

        quiesce();
        $display("Covered %0d accepted words over %0d setting phases: %0d notes started,",
                 n_words, n_phases, n_notes);
        $display("%0d rendered frames compared, %0d mismatches.", frames_checked, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
